// ===== hw/rtl/ssbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ssbs_pkg
// Shared types and constants of the sorted store bracket search unit.
// ----------------------------------------------------------------------------
package ssbs_pkg;

	// Store geometry
	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int VALUE_W     = 40;
	localparam int OP_W        = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	// Input item
	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [VALUE_W-1:0] operand_value;
	} ssbs_cmd_t;

	// Result item
	typedef struct packed {
		logic [OP_W-1:0]    result_kind;
		logic [VALUE_W-1:0] below_value;
		logic               below_found;
		logic [VALUE_W-1:0] above_value;
		logic               above_found;
		logic               store_full;
	} ssbs_result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // latch item, clear result, open search window
		logic append;     // write next free entry or flag full
		logic clear;      // empty the store
		logic probe_rd;   // read entry at window middle
		logic probe_cmp;  // compare read entry and narrow window
	} ssbs_dp_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            search_live;  // window not empty
		logic            probe_hit;    // probed entry equals target
	} ssbs_dp_sts_t;

endpackage

// ===== hw/rtl/ssbs_dp.sv =====
// ----------------------------------------------------------------------------
// ssbs_dp
// Datapath: value store memory, fill count, search window and result
// registers.
// ----------------------------------------------------------------------------
module ssbs_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssbs_pkg::ssbs_cmd_t   cmd,
	input  ssbs_pkg::ssbs_dp_ctl_t ctl,
	output ssbs_pkg::ssbs_dp_sts_t sts,
	output ssbs_pkg::ssbs_result_t result
);
	import ssbs_pkg::*;

	logic [VALUE_W-1:0] mem_q [STORE_DEPTH];
	logic [VALUE_W-1:0] rd_data_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hi_x_q;     // one past the window's upper end
	logic [ADDR_W-1:0]  mid_q;
	logic [OP_W-1:0]    op_q;
	logic [VALUE_W-1:0] target_q;
	logic [VALUE_W-1:0] below_q;
	logic [VALUE_W-1:0] above_q;
	logic               below_ok_q;
	logic               above_ok_q;
	logic               full_q;
	logic [CNT_W:0]     mid_sum;
	logic [ADDR_W-1:0]  mid;
	logic               has_room;

	// Window middle: floor((lo + hi) / 2) with hi = hi_x - 1
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_x_q} - {{CNT_W{1'b0}}, 1'b1};
	assign mid      = mid_sum[ADDR_W:1];
	assign has_room = (fill_q < CNT_W'(STORE_DEPTH));

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (ctl.append && has_room) begin
			mem_q[fill_q[ADDR_W-1:0]] <= target_q;
		end
		if (ctl.probe_rd) begin
			rd_data_q <= mem_q[mid];
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.clear) begin
			fill_q <= '0;
		end else if (ctl.append && has_room) begin
			fill_q <= fill_q + CNT_W'(1);
		end
	end

	// Item latch, search window and result fields
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q       <= cmd.opcode;
			target_q   <= cmd.operand_value;
			lo_q       <= '0;
			hi_x_q     <= fill_q;
			below_q    <= '0;
			above_q    <= '0;
			below_ok_q <= 1'b0;
			above_ok_q <= 1'b0;
			full_q     <= 1'b0;
		end else begin
			if (ctl.append && !has_room) begin
				full_q <= 1'b1;
			end
			if (ctl.probe_rd) begin
				mid_q <= mid;
			end
			if (ctl.probe_cmp) begin
				if (rd_data_q < target_q) begin
					below_q    <= rd_data_q;
					below_ok_q <= 1'b1;
					lo_q       <= {1'b0, mid_q} + CNT_W'(1);
				end else if (rd_data_q > target_q) begin
					above_q    <= rd_data_q;
					above_ok_q <= 1'b1;
					hi_x_q     <= {1'b0, mid_q};
				end else begin
					below_q    <= rd_data_q;
					above_q    <= rd_data_q;
					below_ok_q <= 1'b1;
					above_ok_q <= 1'b1;
				end
			end
		end
	end

	// Status toward the controller
	assign sts.op          = op_q;
	assign sts.search_live = (lo_q < hi_x_q);
	assign sts.probe_hit   = (rd_data_q == target_q);

	// Result fields
	assign result.result_kind = op_q;
	assign result.below_value = below_q;
	assign result.below_found = below_ok_q;
	assign result.above_value = above_q;
	assign result.above_found = above_ok_q;
	assign result.store_full  = full_q;

endmodule

// ===== hw/rtl/ssbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssbs_ctrl
// Controller: sequences append, clear and binary search probes and raises
// the result strobe.
// ----------------------------------------------------------------------------
module ssbs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  ssbs_pkg::ssbs_dp_sts_t sts,
	output ssbs_pkg::ssbs_dp_ctl_t ctl,
	output logic                   busy,
	output logic                   done
);
	import ssbs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PROBE,
		ST_CMP,
		ST_REPLY
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						busy_q  <= 1'b1;
					end
				end
				ST_EXEC: begin
					if (sts.op == OP_QUERY) begin
						state_q <= ST_PROBE;
					end else begin
						state_q <= ST_REPLY;
						done_q  <= 1'b1;
					end
				end
				ST_PROBE: begin
					if (sts.search_live) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_REPLY;
						done_q  <= 1'b1;
					end
				end
				ST_CMP: begin
					if (sts.probe_hit) begin
						state_q <= ST_REPLY;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				ST_REPLY: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// Datapath commands
	always_comb begin
		ctl           = '0;
		ctl.load      = start && !busy_q;
		ctl.append    = (state_q == ST_EXEC) && (sts.op == OP_APPEND);
		ctl.clear     = (state_q == ST_EXEC) && (sts.op == OP_CLEAR);
		ctl.probe_rd  = (state_q == ST_PROBE) && sts.search_live;
		ctl.probe_cmp = (state_q == ST_CMP);
	end

	assign busy = busy_q;
	assign done = done_q;

	// A result strobe only ever falls inside a busy transfer
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside busy");

	// The strobe lasts exactly one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// An accepted item makes the unit busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not raise busy");

	// Busy drops only right after the strobe
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

endmodule

// ===== hw/rtl/sorted_store_bracket_search_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_store_bracket_search_unit
// Append-only sorted value store with predecessor/successor lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd and pulse start while busy is low; the item transfers at that
//   edge and busy rises. opcode append writes the next free entry (or sets
//   store_full when all STORE_DEPTH entries hold data), query runs a binary
//   search for operand_value and reports the largest stored value below it
//   and the smallest above it (the target itself on an exact match), clear
//   empties the store. Each item yields one result, shown on result for
//   exactly one cycle while done is high; the receiver must take it then.
//   Append, clear and the unused code run no probes; a query runs P probes
//   (P <= 11 for 1024 entries) and stops on an exact hit or an empty
//   window. Each probe does the synchronous store read in ST_PROBE and the
//   compare in ST_CMP. busy stays high through the done cycle and drops
//   right after it, so the next item can transfer only after the result:
//   a new item is never taken while one is in flight.
//   Reset empties the store (fill count to zero) and returns to idle; store
//   contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_store_bracket_search_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  ssbs_pkg::ssbs_cmd_t    cmd,
	output logic                   busy,
	output logic                   done,
	output ssbs_pkg::ssbs_result_t result
);
	import ssbs_pkg::*;

	ssbs_dp_ctl_t ctl;
	ssbs_dp_sts_t sts;

	// Sequencer
	ssbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// Store and search datapath
	ssbs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.result (result)
	);

endmodule

// ===== dv/tb_sorted_store_bracket_search_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_store_bracket_search_unit
// Self-checking bench: a short table of directed commands, a fill of the
// store past capacity, then random append/query/clear episodes.
// Every transferred command is run through a local copy of the store and its
// bracket search; each done strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_store_bracket_search_unit;
	import ssbs_pkg::*;

	localparam logic [OP_W-1:0]    OP_UNUSED = 2'd3;
	localparam logic [VALUE_W-1:0] VAL_MAX   = {VALUE_W{1'b1}};
	localparam int ITEM_GOAL  = 1900;
	localparam int DRAIN_WAIT = 40;

	typedef struct {
		ssbs_cmd_t    c;
		bit           known;
		ssbs_result_t r;
	} dir_row_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         start  = 1'b0;
	ssbs_cmd_t    cmd    = '0;
	logic         busy;
	logic         done;
	ssbs_result_t result;

	// Bench copy of the store
	logic [VALUE_W-1:0] kept_vals [STORE_DEPTH];
	int                 kept_count = 0;
	logic [VALUE_W-1:0] last_val   = '0;

	ssbs_result_t pending_results [$];
	int           mismatch_n = 0;
	int           sent_n     = 0;
	bit           no_idle    = 1'b0;

	sorted_store_bracket_search_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one command to the bench store and return its result
	function automatic ssbs_result_t bracket_predict(input ssbs_cmd_t c);
		ssbs_result_t       r;
		int                 lo;
		int                 hi;
		int                 mid;
		bit                 hunting;
		logic [VALUE_W-1:0] probe;
		r = '0;
		r.result_kind = c.opcode;
		case (c.opcode)
			OP_APPEND: begin
				if (kept_count < STORE_DEPTH) begin
					kept_vals[kept_count] = c.operand_value;
					kept_count++;
				end else begin
					r.store_full = 1'b1;
				end
			end
			OP_QUERY: begin
				lo = 0;
				hi = kept_count - 1;
				hunting = 1'b1;
				while (hunting && lo <= hi) begin
					mid = (lo + hi) / 2;
					probe = kept_vals[mid];
					if (probe < c.operand_value) begin
						r.below_value = probe;
						r.below_found = 1'b1;
						lo = mid + 1;
					end else if (probe > c.operand_value) begin
						r.above_value = probe;
						r.above_found = 1'b1;
						hi = mid - 1;
					end else begin
						r.below_value = probe;
						r.above_value = probe;
						r.below_found = 1'b1;
						r.above_found = 1'b1;
						hunting = 1'b0;
					end
				end
			end
			OP_CLEAR: kept_count = 0;
			default: ;
		endcase
		return r;
	endfunction

	function automatic ssbs_cmd_t mk(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v);
		ssbs_cmd_t c;
		c.opcode        = op;
		c.operand_value = v;
		return c;
	endfunction

	function automatic ssbs_result_t res(input logic [OP_W-1:0] k,
			input logic [VALUE_W-1:0] bv, input logic bf,
			input logic [VALUE_W-1:0] av, input logic af, input logic sf);
		ssbs_result_t r;
		r.result_kind = k;
		r.below_value = bv;
		r.below_found = bf;
		r.above_value = av;
		r.above_found = af;
		r.store_full  = sf;
		return r;
	endfunction

	function automatic dir_row_t row(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v,
			input bit known, input ssbs_result_t r);
		dir_row_t d;
		d.c     = mk(op, v);
		d.known = known;
		d.r     = r;
		return d;
	endfunction

	function automatic logic [VALUE_W-1:0] rand40();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[VALUE_W-1:0];
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Next value of an ascending run, saturating at the top of the range
	function automatic logic [VALUE_W-1:0] next_up(input int unsigned step);
		logic [VALUE_W:0] t;
		t = {1'b0, last_val} + (VALUE_W+1)'($urandom_range(0, step));
		last_val = t[VALUE_W] ? VAL_MAX : t[VALUE_W-1:0];
		return last_val;
	endfunction

	// Target near stored values, at the extremes, or anywhere
	function automatic logic [VALUE_W-1:0] pick_target();
		int                 r;
		logic [VALUE_W-1:0] v;
		r = $urandom_range(0, 9);
		if (kept_count == 0 || r >= 8) return rand40();
		if (r == 0) return '0;
		if (r == 1) return VAL_MAX;
		v = kept_vals[$urandom_range(0, kept_count - 1)];
		if (r <= 4) return v;
		if (r <= 6) return v + 1'b1;
		return v - 1'b1;
	endfunction

	// Unused code, out-of-order append, or blind query
	function automatic ssbs_cmd_t noise_cmd();
		case ($urandom_range(0, 2))
			0: return mk(OP_UNUSED, rand40());
			1: return mk(OP_APPEND, rand40());
			default: return mk(OP_QUERY, rand40());
		endcase
	endfunction

	// Offer one command, hold until it transfers, then idle a while
	task automatic issue(input ssbs_cmd_t c, input bit known, input ssbs_result_t known_r);
		ssbs_result_t pred;
		int           gap;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = bracket_predict(c);
		pending_results.push_back(known ? known_r : pred);
		sent_n++;
		gap = no_idle ? 0 : idle_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue_pred(input ssbs_cmd_t c);
		issue(c, 1'b0, '0);
	endtask

	// Hold off until every outstanding result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic cmp_field(input string name, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatch_n++;
		end
	endtask

	// Check each result against the oldest prediction
	always @(posedge clk) begin
		ssbs_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result_kind: expected none, actual %0h", result.result_kind);
				mismatch_n++;
			end else begin
				want = pending_results.pop_front();
				cmp_field("result_kind", VALUE_W'(want.result_kind),
					VALUE_W'(result.result_kind));
				cmp_field("below_value", want.below_value, result.below_value);
				cmp_field("below_found", VALUE_W'(want.below_found),
					VALUE_W'(result.below_found));
				cmp_field("above_value", want.above_value, result.above_value);
				cmp_field("above_found", VALUE_W'(want.above_found),
					VALUE_W'(result.above_found));
				cmp_field("store_full", VALUE_W'(want.store_full),
					VALUE_W'(result.store_full));
			end
		end
	end

	// Stimulus
	initial begin
		dir_row_t    dir_rows [$];
		int          i;
		int          n_app;
		int          n_q;
		int unsigned step;

		// Directed table: empty store, extremes, exact hits, clear, bad order
		dir_rows.push_back(row(OP_QUERY, 40'd0, 1'b1,
			res(OP_QUERY, '0, 1'b0, '0, 1'b0, 1'b0)));
		dir_rows.push_back(row(OP_UNUSED, VAL_MAX, 1'b1,
			res(OP_UNUSED, '0, 1'b0, '0, 1'b0, 1'b0)));
		dir_rows.push_back(row(OP_APPEND, 40'd0, 1'b1,
			res(OP_APPEND, '0, 1'b0, '0, 1'b0, 1'b0)));
		dir_rows.push_back(row(OP_APPEND, 40'd5, 1'b1,
			res(OP_APPEND, '0, 1'b0, '0, 1'b0, 1'b0)));
		dir_rows.push_back(row(OP_APPEND, VAL_MAX, 1'b1,
			res(OP_APPEND, '0, 1'b0, '0, 1'b0, 1'b0)));
		dir_rows.push_back(row(OP_QUERY, 40'd0, 1'b1,
			res(OP_QUERY, '0, 1'b1, '0, 1'b1, 1'b0)));
		dir_rows.push_back(row(OP_QUERY, VAL_MAX, 1'b1,
			res(OP_QUERY, VAL_MAX, 1'b1, VAL_MAX, 1'b1, 1'b0)));
		dir_rows.push_back(row(OP_QUERY, 40'd3, 1'b0, '0));
		dir_rows.push_back(row(OP_QUERY, 40'd6, 1'b0, '0));
		dir_rows.push_back(row(OP_QUERY, 40'd5, 1'b0, '0));
		dir_rows.push_back(row(OP_CLEAR, VAL_MAX, 1'b1,
			res(OP_CLEAR, '0, 1'b0, '0, 1'b0, 1'b0)));
		dir_rows.push_back(row(OP_QUERY, 40'd5, 1'b1,
			res(OP_QUERY, '0, 1'b0, '0, 1'b0, 1'b0)));
		dir_rows.push_back(row(OP_APPEND, 40'd100, 1'b0, '0));
		dir_rows.push_back(row(OP_APPEND, 40'd50, 1'b0, '0));
		dir_rows.push_back(row(OP_APPEND, 40'h55_5555_5555, 1'b0, '0));
		dir_rows.push_back(row(OP_QUERY, 40'd60, 1'b0, '0));
		dir_rows.push_back(row(OP_QUERY, 40'd40, 1'b0, '0));
		dir_rows.push_back(row(OP_QUERY, 40'd100, 1'b0, '0));
		dir_rows.push_back(row(OP_QUERY, 40'hAA_AAAA_AAAA, 1'b0, '0));
		dir_rows.push_back(row(OP_CLEAR, 40'd0, 1'b1,
			res(OP_CLEAR, '0, 1'b0, '0, 1'b0, 1'b0)));
		dir_rows.push_back(row(OP_APPEND, 40'd1, 1'b1,
			res(OP_APPEND, '0, 1'b0, '0, 1'b0, 1'b0)));
		dir_rows.push_back(row(OP_QUERY, 40'd0, 1'b0, '0));
		dir_rows.push_back(row(OP_QUERY, 40'd2, 1'b0, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r_idx])
			issue(dir_rows[r_idx].c, dir_rows[r_idx].known, dir_rows[r_idx].r);
		drain();

		// Fill the store past capacity with queries mixed in, then probe it full
		issue_pred(mk(OP_CLEAR, rand40()));
		last_val = rand40() >> 12;
		i = 0;
		while (i < STORE_DEPTH + 6) begin
			no_idle = (i % 256) < 64;
			if ($urandom_range(0, 7) == 0) begin
				issue_pred(mk(OP_QUERY, pick_target()));
			end else begin
				issue_pred(mk(OP_APPEND, next_up(1 << 20)));
				i++;
			end
		end
		no_idle = 1'b0;
		repeat (24) issue_pred(mk(OP_QUERY, pick_target()));
		drain();

		// Random episodes: mostly clear, ascending run, queries; some noise
		while (sent_n < ITEM_GOAL) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				issue_pred(mk(OP_CLEAR, rand40()));
				last_val = rand40() >> $urandom_range(0, VALUE_W);
			end
			case ($urandom_range(0, 3))
				0: step = 0;
				1: step = 3;
				2: step = 1000;
				default: step = 32'hFFFF_FFFF;
			endcase
			n_app = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
			repeat (n_app) begin
				if ($urandom_range(0, 19) == 0)
					issue_pred(noise_cmd());
				issue_pred(mk(OP_APPEND, next_up(step)));
			end
			n_q = $urandom_range(4, 20);
			repeat (n_q) begin
				if ($urandom_range(0, 19) == 0)
					issue_pred(noise_cmd());
				issue_pred(mk(OP_QUERY, pick_target()));
			end
			if ($urandom_range(0, 15) == 0)
				drain();
		end

		// Wait out the last results, then allow stray strobes to show
		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_n == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sorted_store_bracket_search_unit.f =====
hw/rtl/ssbs_pkg.sv
hw/rtl/ssbs_dp.sv
hw/rtl/ssbs_ctrl.sv
hw/rtl/sorted_store_bracket_search_unit.sv
dv/tb_sorted_store_bracket_search_unit.sv
